// File: rtl/cfcr_pkg.sv
// Package for the CAN frame capture responder: transaction structs,
// event codes and the fixed frame constants. No dependencies.
package cfcr_pkg;

    // Event codes carried in req_type
    localparam logic [1:0] REQ_REQUEST   = 2'd0;
    localparam logic [1:0] REQ_CANDIDATE = 2'd1;
    localparam logic [1:0] REQ_CANCEL    = 2'd2;

    // Fixed identifiers and response bytes
    localparam logic [28:0] REQ_ID       = 29'h18DABAF1;
    localparam logic [28:0] RSP_ID       = 29'h18DAF1BA;
    localparam logic [7:0]  RSP_LEN_BYTE = 8'h07;
    localparam logic [7:0]  RSP_SID_BYTE = 8'h62;
    localparam logic [3:0]  MIN_REQ_DLC  = 4'd7;
    localparam logic [3:0]  MAX_DLC      = 4'd8;
    localparam int          MAX_PAYLOAD  = 5;

    // Input transaction: one CAN frame event
    typedef struct packed {
        logic [1:0]  req_type;
        logic        frame_extended;
        logic [28:0] frame_id;
        logic [3:0]  frame_dlc;
        logic [63:0] frame_data;
        logic [31:0] frame_time;
    } t_cfcr_in;

    // Output transaction: one result per event
    typedef struct packed {
        logic        accepted;
        logic        response_valid;
        logic [63:0] response_data;
        logic [31:0] response_time;
    } t_cfcr_out;

endpackage

// File: rtl/cfcr_core.sv
// Capture state and per-event decision logic of the CAN frame capture
// responder. Depends on cfcr_pkg.
module cfcr_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    input  logic               i_fire,
    input  cfcr_pkg::t_cfcr_in i_item,
    output cfcr_pkg::t_cfcr_out o_result
);
    import cfcr_pkg::*;

    logic        r_enabled;
    logic        r_armed;
    logic        r_tgt_ext;
    logic [3:0]  r_offset;
    logic [7:0]  r_desc;
    logic [31:0] r_tgt_id;

    logic        n_armed;
    logic        n_tgt_ext;
    logic [3:0]  n_offset;
    logic [7:0]  n_desc;
    logic [31:0] n_tgt_id;

    logic        req_ok;
    logic        cand_hit;
    logic [3:0]  len;
    logic        in_range;
    logic [63:0] shifted;
    logic [7:0]  b2;
    logic [4:0]  pos;

    // Event decode and next capture state
    always_comb begin
        b2        = i_item.frame_data[23:16];
        req_ok    = (i_item.req_type == REQ_REQUEST) && r_enabled &&
                    i_item.frame_extended && (i_item.frame_id == REQ_ID) &&
                    (i_item.frame_dlc >= MIN_REQ_DLC);
        cand_hit  = (i_item.req_type == REQ_CANDIDATE) && r_enabled && r_armed &&
                    (i_item.frame_extended == r_tgt_ext) &&
                    ({3'b000, i_item.frame_id} == r_tgt_id);
        len       = (i_item.frame_dlc > MAX_DLC) ? MAX_DLC : i_item.frame_dlc;
        in_range  = r_offset < len;
        shifted   = i_item.frame_data >> {r_offset[2:0], 3'b000};

        n_armed   = r_armed;
        n_tgt_ext = r_tgt_ext;
        n_offset  = r_offset;
        n_desc    = r_desc;
        n_tgt_id  = r_tgt_id;
        if (req_ok) begin
            n_armed   = 1'b1;
            n_tgt_ext = b2[7:4] != 4'd0;
            n_offset  = b2[3:0];
            n_desc    = b2;
            n_tgt_id  = {i_item.frame_data[31:24], i_item.frame_data[39:32],
                         i_item.frame_data[47:40], i_item.frame_data[55:48]};
        end else if (cand_hit || (i_item.req_type == REQ_CANCEL)) begin
            n_armed = 1'b0;
        end
    end

    // Result build: header bytes, then up to five bytes from the offset
    always_comb begin
        o_result = '0;
        pos      = '0;
        if (req_ok) begin
            o_result.accepted = 1'b1;
        end else if (cand_hit && in_range) begin
            o_result.accepted       = 1'b1;
            o_result.response_valid = 1'b1;
            o_result.response_time  = i_item.frame_time;
            o_result.response_data[7:0]   = RSP_LEN_BYTE;
            o_result.response_data[15:8]  = RSP_SID_BYTE;
            o_result.response_data[23:16] = r_desc;
            for (int k = 0; k < MAX_PAYLOAD; k++) begin
                pos = {1'b0, r_offset} + 5'(k);
                if (pos < {1'b0, len}) begin
                    o_result.response_data[(3 + k) * 8 +: 8] = shifted[k * 8 +: 8];
                end
            end
        end
    end

    // Enable register and capture state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enabled <= 1'b0;
            r_armed   <= 1'b0;
            r_tgt_ext <= 1'b0;
            r_offset  <= '0;
            r_desc    <= '0;
            r_tgt_id  <= '0;
        end else begin
            if (i_cfg_we) begin
                r_enabled <= i_cfg_wdata;
            end
            if (i_fire) begin
                r_armed   <= n_armed;
                r_tgt_ext <= n_tgt_ext;
                r_offset  <= n_offset;
                r_desc    <= n_desc;
                r_tgt_id  <= n_tgt_id;
            end
        end
    end

endmodule

// File: rtl/can_frame_capture_responder.sv
// Top level of the CAN frame capture responder: input register, result
// register and handshake control around cfcr_core. Depends on cfcr_pkg.
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) takes one CAN
//   frame event per transaction: request, candidate or cancel. Output
//   channel (o_out_valid / i_out_stall / o_out_data) returns exactly one
//   result transaction per event, in order.
//   A request to the diagnostic ID arms a one-shot capture; a matching
//   candidate disarms it and, if the stored offset lies inside its data,
//   yields a response payload with the candidate's timestamp. The user
//   writes the enable register (i_cfg_we / i_cfg_wdata) only while idle;
//   the block itself does not enforce this.
// Pipeline:
//   An event passes from the input register through the decision logic
//   into the result register; one event per cycle when not stalled.
// Reset and stall:
//   Reset clears both valid flags, disarms the capture and disables the
//   block. While the receiver stalls, the result holds; an empty input
//   register still takes one event, and only then does o_in_stall rise.
module can_frame_capture_responder (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic                i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  cfcr_pkg::t_cfcr_in  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output cfcr_pkg::t_cfcr_out o_out_data
);
    import cfcr_pkg::*;

    logic      r_in_vld;
    t_cfcr_in  r_in;
    logic      r_out_vld;
    t_cfcr_out r_out;

    logic      advance;
    logic      fire;
    t_cfcr_out result;

    // Handshake control
    assign advance    = !r_out_vld || !i_out_stall;
    assign fire       = r_in_vld && advance;
    assign o_in_stall = r_in_vld && !advance;

    cfcr_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_fire      (fire),
        .i_item      (r_in),
        .o_result    (result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance) begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= result;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

// File: rtl/cfcr_chk.sv
// Port-level checker for the CAN frame capture responder, bound to the
// top level. Depends on cfcr_pkg.
module cfcr_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input cfcr_pkg::t_cfcr_out o_out_data
);
    import cfcr_pkg::*;

    // A stalled result transaction stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("result dropped while stalled");

    // Nothing is pending right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("pipeline not empty after reset");

    // A response always counts as accepted and carries the fixed header
    a_rsp_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.response_valid |->
            o_out_data.accepted &&
            o_out_data.response_data[7:0] == RSP_LEN_BYTE &&
            o_out_data.response_data[15:8] == RSP_SID_BYTE)
        else $error("response without header or accept");

    // Without a response the response fields are zero
    a_no_rsp_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.response_valid |->
            o_out_data.response_data == '0 && o_out_data.response_time == '0)
        else $error("stale response fields");

    // Input stalls only when a result is waiting on a stalled receiver
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

endmodule

bind can_frame_capture_responder cfcr_chk u_cfcr_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// File: sim/tb_top.sv
// Self-checking testbench for can_frame_capture_responder: directed and random
// CAN frame events, predicted results checked in order. Depends on cfcr_pkg and the RTL.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import cfcr_pkg::*;

    // Selector value the block leaves unused
    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 300000;
    localparam int         HOLD_CYCLES = 300;

    // Tracks the responder state and the results still owed by the block
    class capture_tracker;
        logic        enable;
        logic        armed;
        logic        tgt_ext;
        logic [3:0]  offset;
        logic [7:0]  desc;
        logic [31:0] tgt_id;
        t_cfcr_out   awaited_results[$];
        int          events;
        int          arms;
        int          replies;
        int          checked;
        int          errors;

        function new();
            enable  = 1'b0;
            armed   = 1'b0;
            tgt_ext = 1'b0;
            offset  = '0;
            desc    = '0;
            tgt_id  = '0;
        endfunction

        // Next state and the one result caused by a frame event
        function t_cfcr_out compute_reply(t_cfcr_in ev);
            t_cfcr_out  res;
            logic [7:0] b2;
            logic [3:0] len;
            int         n;
            res = '0;
            case (ev.req_type)
                REQ_REQUEST: begin
                    if (enable && ev.frame_extended && ev.frame_id == REQ_ID &&
                        ev.frame_dlc >= MIN_REQ_DLC) begin
                        b2      = ev.frame_data[23:16];
                        tgt_ext = (b2[7:4] != 4'd0);
                        offset  = b2[3:0];
                        desc    = b2;
                        tgt_id  = {ev.frame_data[31:24], ev.frame_data[39:32],
                                   ev.frame_data[47:40], ev.frame_data[55:48]};
                        armed   = 1'b1;
                        res.accepted = 1'b1;
                        arms++;
                    end
                end
                REQ_CANDIDATE: begin
                    if (enable && armed && ev.frame_extended == tgt_ext &&
                        {3'b000, ev.frame_id} == tgt_id) begin
                        len   = (ev.frame_dlc > MAX_DLC) ? MAX_DLC : ev.frame_dlc;
                        armed = 1'b0;
                        if (offset < len) begin
                            n = int'(len) - int'(offset);
                            if (n > MAX_PAYLOAD)
                                n = MAX_PAYLOAD;
                            res.response_data[7:0]   = RSP_LEN_BYTE;
                            res.response_data[15:8]  = RSP_SID_BYTE;
                            res.response_data[23:16] = desc;
                            for (int k = 0; k < n; k++)
                                res.response_data[8*(3+k) +: 8] =
                                    ev.frame_data[8*(int'(offset)+k) +: 8];
                            res.response_time  = ev.frame_time;
                            res.response_valid = 1'b1;
                            res.accepted       = 1'b1;
                            replies++;
                        end
                    end
                end
                REQ_CANCEL: armed = 1'b0;
                default: ;
            endcase
            return res;
        endfunction

        function void note_event(t_cfcr_in ev);
            events++;
            awaited_results.push_back(compute_reply(ev));
        endfunction

        function int pending();
            return awaited_results.size();
        endfunction

        task report_mismatch(string field, logic [63:0] got, logic [63:0] want);
            $display("MISMATCH at %0t: %s got %h want %h", $time, field, got, want);
            errors++;
        endtask

        // Compare one result transaction with the oldest prediction
        task check_reply(t_cfcr_out got);
            t_cfcr_out want;
            if (awaited_results.size() == 0) begin
                report_mismatch("result with nothing awaited", got.response_data, '0);
            end else begin
                want = awaited_results.pop_front();
                checked++;
                if (got.accepted !== want.accepted)
                    report_mismatch("accepted", 64'(got.accepted), 64'(want.accepted));
                if (got.response_valid !== want.response_valid)
                    report_mismatch("response_valid", 64'(got.response_valid),
                                    64'(want.response_valid));
                if (got.response_data !== want.response_data)
                    report_mismatch("response_data", got.response_data,
                                    want.response_data);
                if (got.response_time !== want.response_time)
                    report_mismatch("response_time", 64'(got.response_time),
                                    64'(want.response_time));
            end
        endtask
    endclass

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic       i_cfg_wdata = 1'b0;
    logic       i_in_valid = 1'b0;
    logic       o_in_stall;
    t_cfcr_in   i_in_data = '0;
    logic       o_out_valid;
    logic       i_out_stall = 1'b0;
    t_cfcr_out  o_out_data;

    capture_tracker sb = new();

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_seq = 0;
    int hold_seen = 0;
    int hold_left = 0;
    int cycles = 0;

    can_frame_capture_responder u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // 10 ns clock
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    // Result side: check each transaction, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall)
                sb.check_reply(o_out_data);
            if (hold_seq != hold_seen) begin
                hold_seen = hold_seq;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
        end
    end

    // Offer one frame event and wait until the block takes it
    task send_event(t_cfcr_in ev);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= ev;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        sb.note_event(ev);
    endtask

    task wait_drained();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Enable register write, only with nothing in flight
    task set_enable(logic value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.enable = value;
    endtask

    function t_cfcr_in make_request(logic [7:0] b2, logic [31:0] tgt, logic [3:0] dlc);
        t_cfcr_in ev;
        ev.req_type       = REQ_REQUEST;
        ev.frame_extended = 1'b1;
        ev.frame_id       = REQ_ID;
        ev.frame_dlc      = dlc;
        ev.frame_data     = {$urandom, $urandom};
        ev.frame_data[23:16] = b2;
        ev.frame_data[55:24] = {tgt[7:0], tgt[15:8], tgt[23:16], tgt[31:24]};
        ev.frame_time     = $urandom;
        return ev;
    endfunction

    function t_cfcr_in make_frame(logic [1:0] kind, logic ext, logic [28:0] id,
                                  logic [3:0] dlc, logic [63:0] data, logic [31:0] stamp);
        t_cfcr_in ev;
        ev.req_type       = kind;
        ev.frame_extended = ext;
        ev.frame_id       = id;
        ev.frame_dlc      = dlc;
        ev.frame_data     = data;
        ev.frame_time     = stamp;
        return ev;
    endfunction

    function t_cfcr_in noise_event();
        logic [28:0] id;
        id = ($urandom_range(3) == 0) ? REQ_ID : 29'($urandom);
        return make_frame(2'($urandom), 1'($urandom), id, 4'($urandom),
                          {$urandom, $urandom}, $urandom);
    endfunction

    // Mostly request / candidate pairs with random content, the rest noise
    task send_burst();
        logic [7:0]  b2;
        logic [31:0] tgt;
        logic [3:0]  dlc;
        if ($urandom_range(99) < 65) begin
            b2  = 8'($urandom);
            if ($urandom_range(3) != 0)
                b2[3:0] = 4'($urandom_range(0, 9));
            tgt = ($urandom_range(9) == 0) ? 32'($urandom) : {3'b000, 29'($urandom)};
            dlc = ($urandom_range(2) == 0) ? 4'($urandom) : MAX_DLC;
            send_event(make_request(b2, tgt, 4'($urandom_range(7, 15))));
            repeat ($urandom_range(0, 2))
                send_event(noise_event());
            if ($urandom_range(9) == 0)
                send_event(make_frame(REQ_CANCEL, 1'($urandom), 29'($urandom),
                                      4'($urandom), {$urandom, $urandom}, $urandom));
            send_event(make_frame(REQ_CANDIDATE, b2[7:4] != 4'd0, tgt[28:0], dlc,
                                  {$urandom, $urandom}, $urandom));
        end else begin
            send_event(noise_event());
        end
    endtask

    task run_random(int count);
        int stop_at;
        stop_at = sb.events + count;
        while (sb.events < stop_at)
            send_burst();
        wait_drained();
    endtask

    // Main sequence
    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Disabled: request and candidate ignored, cancel and unused selector
        set_enable(1'b0);
        send_event(make_request(8'h10, 32'h0000_0123, 4'd8));
        send_event(make_frame(REQ_CANDIDATE, 1'b1, 29'h123, 4'd8, '1, '1));
        send_event(make_frame(REQ_CANCEL, 1'b0, '0, '0, '0, '0));
        send_event(make_frame(REQ_UNUSED, 1'b1, '1, 4'hF, '1, '1));
        set_enable(1'b1);

        // Arm, wrong flavor, full capture, then no longer armed
        send_event(make_request(8'h13, 32'h0ABC_DEF1, 4'd8));
        send_event(make_frame(REQ_CANDIDATE, 1'b0, 29'h0ABCDEF1, 4'd8, '1, '1));
        send_event(make_frame(REQ_CANDIDATE, 1'b1, 29'h0ABCDEF1, 4'd8, '1, '1));
        send_event(make_frame(REQ_CANDIDATE, 1'b1, 29'h0ABCDEF1, 4'd8, '1, '1));
        // Requests rejected: standard frame, short DLC, wrong ID
        send_event(make_frame(REQ_REQUEST, 1'b0, REQ_ID, 4'd8, 64'h0000_0001_0000_0000, 0));
        send_event(make_request(8'h10, 32'h0000_0001, 4'd6));
        send_event(make_frame(REQ_REQUEST, 1'b1, REQ_ID ^ 29'h1, 4'd8, '0, '0));
        // DLC above eight on a request, then a re-request overwrites it
        send_event(make_request(8'h06, 32'h1FFF_FFFF, 4'd15));
        send_event(make_request(8'hF0, 32'h0000_0000, 4'd7));
        send_event(make_frame(REQ_CANDIDATE, 1'b1, '0, 4'd15,
                              64'h0123_4567_89AB_CDEF, '0));
        // Offset near the end: short payload with zero padding
        send_event(make_request(8'h06, 32'h0000_07FF, 4'd8));
        send_event(make_frame(REQ_CANDIDATE, 1'b0, 29'h7FF, 4'd8,
                              64'hFEDC_BA98_7654_3210, 32'h8000_0000));
        // Offset not inside the data: consumed without response
        send_event(make_request(8'h25, 32'h0000_0055, 4'd8));
        send_event(make_frame(REQ_CANDIDATE, 1'b1, 29'h55, 4'd4, '1, '1));
        send_event(make_frame(REQ_CANDIDATE, 1'b1, 29'h55, 4'd8, '1, '1));
        send_event(make_request(8'h1F, 32'h0000_AAAA, 4'd8));
        send_event(make_frame(REQ_CANDIDATE, 1'b1, 29'hAAAA, 4'd15, '1, '1));
        // Target with upper bits set never fires
        send_event(make_request(8'h10, 32'hE000_0001, 4'd8));
        send_event(make_frame(REQ_CANDIDATE, 1'b1, 29'h1, 4'd8, '1, '1));
        // Cancel while armed
        send_event(make_request(8'h10, 32'h0000_0321, 4'd8));
        send_event(make_frame(REQ_CANCEL, 1'b1, '1, 4'hF, '1, '1));
        send_event(make_frame(REQ_CANDIDATE, 1'b1, 29'h321, 4'd8, '1, '1));
        send_event(make_frame(REQ_UNUSED, 1'b0, '0, '0, '0, '0));
        wait_drained();

        // Sender idles little, receiver stalls a lot
        send_idle_pct = 21;
        recv_idle_pct <= 73;
        run_random(340);

        // Roles swapped, with a short disabled stretch first
        send_idle_pct = 73;
        recv_idle_pct <= 21;
        set_enable(1'b0);
        run_random(40);
        set_enable(1'b1);
        run_random(340);

        // No idling, long receiver hold so the block backs up
        send_idle_pct = 0;
        recv_idle_pct <= 0;
        hold_seq <= hold_seq + 1;
        run_random(340);

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Run covered %0d frame events, %0d armed requests, %0d responses;",
                 sb.events, sb.arms, sb.replies);
        $display("%0d results checked under three stall profiles and one long hold.",
                 sb.checked);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
